FILE: hw/rtl/nsr_pkg.sv
// ----------------------------------------------------------------------------
// nsr_pkg: shared types and constants for the Newton square root block
// Field widths, register indexes, reset values, status codes and the
// sequencer state encoding.
// ----------------------------------------------------------------------------
package nsr_pkg;

    // default parameter values
    localparam int FRAC_BITS_DEF  = 16;
    localparam int LIMIT_BITS_DEF = 8;

    // fixed field widths
    localparam int GUESS_W    = 32;
    localparam int LIMIT_W    = 8;
    localparam int STEPS_W    = 8;
    localparam int STATUS_W   = 2;
    localparam int TARGET_W   = 31;
    localparam int TOL_W      = 16;
    localparam int CFG_DATA_W = 31;
    localparam int CFG_IDX_W  = 1;

    // datapath widths
    localparam int PROD_W    = 64;
    localparam int DVD_W     = 63;   // |x*x - target| never exceeds 2^62
    localparam int DSR_W     = 33;   // |2x| never exceeds 2^32
    localparam int DIV_CNT_W = 6;

    localparam logic [TARGET_W-1:0] TARGET_RST = 31'd4194304;
    localparam logic [TOL_W-1:0]    TOL_RST    = 16'd7;

    localparam logic signed [PROD_W-1:0] SAT_HI = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [PROD_W-1:0] SAT_LO = 64'shFFFF_FFFF_8000_0000;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TARGET    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STAT_CONVERGED = 2'd0,
        STAT_LIMIT     = 2'd1,
        STAT_ZERO      = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_MUL,
        S_PREP,
        S_DIV,
        S_UPDATE,
        S_CONV,
        S_DONE
    } t_state;

endpackage

FILE: hw/rtl/newton_square_root.sv
// ----------------------------------------------------------------------------
// newton_square_root: fixed-point Newton-Raphson square root
// Each Newton step runs a check, one multiply, one prep, a restoring divider,
// update and convergence check; the result strobe follows the last step
// once the sequencer reaches S_DONE. One word at a time: busy stays high
// until the strobe cycle ends. Results cannot be stalled by the receiver.
// Reset: synchronous, active low; clears the sequencer, target to 64.0 and
// tolerance to 7.
// ----------------------------------------------------------------------------
module newton_square_root #(
    parameter int FRAC_BITS  = nsr_pkg::FRAC_BITS_DEF,
    parameter int LIMIT_BITS = nsr_pkg::LIMIT_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [nsr_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [nsr_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [nsr_pkg::GUESS_W-1:0]    i_initial_guess,
    input  logic [nsr_pkg::LIMIT_W-1:0]           i_iteration_limit,
    output logic                                  o_valid,
    output logic signed [nsr_pkg::GUESS_W-1:0]    o_root,
    output logic [nsr_pkg::STATUS_W-1:0]          o_status,
    output logic [nsr_pkg::STEPS_W-1:0]           o_steps_taken
);

    localparam int PW = nsr_pkg::PROD_W;
    localparam int DW = nsr_pkg::DVD_W;
    localparam int SW = nsr_pkg::DSR_W;
    localparam int XW = nsr_pkg::GUESS_W;

    nsr_pkg::t_state  r_state, n_state;
    nsr_pkg::t_status r_status, n_status;

    logic [nsr_pkg::TARGET_W-1:0]  r_target;
    logic [nsr_pkg::TOL_W-1:0]     r_tol;
    logic signed [XW-1:0]          r_x, n_x;
    logic signed [XW-1:0]          r_x_prev, n_x_prev;
    logic [LIMIT_BITS-1:0]         r_limit, n_limit;
    logic [LIMIT_BITS-1:0]         r_steps, n_steps;
    logic signed [PW-1:0]          r_prod, n_prod;
    logic                          r_neg, n_neg;
    logic [DW-1:0]                 r_dvd, n_dvd;
    logic [SW-1:0]                 r_dsr, n_dsr;
    logic [SW-1:0]                 r_rem, n_rem;
    logic [nsr_pkg::DIV_CNT_W-1:0] r_cnt, n_cnt;

    logic [LIMIT_BITS+nsr_pkg::LIMIT_W-1:0] lim_ext;
    logic [LIMIT_BITS+nsr_pkg::STEPS_W-1:0] steps_ext;
    logic [LIMIT_BITS-1:0]         lim_in;
    logic signed [PW-1:0]          sq;
    logic signed [PW-1:0]          tshift;
    logic signed [PW-1:0]          num;
    logic signed [PW-1:0]          num_abs;
    logic [XW-1:0]                 x_mag;
    logic [SW:0]                   rem_sh;
    logic [SW:0]                   rem_sub;
    logic                          q_bit;
    logic signed [PW-1:0]          q_val;
    logic signed [PW-1:0]          h_val;
    logic signed [PW-1:0]          nx;
    logic [XW-1:0]                 nx_sat;
    logic signed [XW:0]            diff;
    logic [XW:0]                   diff_abs;
    logic                          converged;
    logic                          div_last;

    assign lim_ext   = {{LIMIT_BITS{1'b0}}, i_iteration_limit};
    assign lim_in    = lim_ext[LIMIT_BITS-1:0];
    assign steps_ext = {{nsr_pkg::STEPS_W{1'b0}}, r_steps};

    // one 32x32 signed multiply
    assign sq      = r_x * r_x;
    assign tshift  = $signed(PW'(r_target) << FRAC_BITS);
    assign num     = r_prod - tshift;
    assign num_abs = num[PW-1] ? -num : num;
    assign x_mag   = r_x[XW-1] ? XW'(-r_x) : r_x;

    // restoring divider, one quotient bit per cycle
    assign rem_sh  = {r_rem, r_dvd[DW-1]};
    assign rem_sub = rem_sh - {1'b0, r_dsr};
    assign q_bit   = (rem_sh >= {1'b0, r_dsr});
    assign div_last = (r_cnt == nsr_pkg::DIV_CNT_W'(DW - 1));

    // x - h with saturation to 32 bits
    assign q_val  = $signed({1'b0, r_dvd});
    assign h_val  = r_neg ? -q_val : q_val;
    assign nx     = PW'(r_x) - h_val;
    always_comb begin
        if (nx > nsr_pkg::SAT_HI) begin
            nx_sat = nsr_pkg::SAT_HI[XW-1:0];
        end else if (nx < nsr_pkg::SAT_LO) begin
            nx_sat = nsr_pkg::SAT_LO[XW-1:0];
        end else begin
            nx_sat = nx[XW-1:0];
        end
    end

    assign diff      = (XW+1)'(r_x) - (XW+1)'(r_x_prev);
    assign diff_abs  = diff[XW] ? (XW+1)'(-diff) : diff;
    assign converged = (diff_abs < (XW+1)'(r_tol));

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= nsr_pkg::TARGET_RST;
            r_tol    <= nsr_pkg::TOL_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                nsr_pkg::REG_TARGET:    r_target <= i_cfg_data[nsr_pkg::TARGET_W-1:0];
                nsr_pkg::REG_TOLERANCE: r_tol    <= i_cfg_data[nsr_pkg::TOL_W-1:0];
                default: ;
            endcase
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            nsr_pkg::S_IDLE: begin
                if (start) n_state = nsr_pkg::S_CHECK;
            end
            nsr_pkg::S_CHECK: begin
                if (r_steps >= r_limit || r_x == '0) begin
                    n_state = nsr_pkg::S_DONE;
                end else begin
                    n_state = nsr_pkg::S_MUL;
                end
            end
            nsr_pkg::S_MUL:    n_state = nsr_pkg::S_PREP;
            nsr_pkg::S_PREP:   n_state = nsr_pkg::S_DIV;
            nsr_pkg::S_DIV: begin
                if (div_last) n_state = nsr_pkg::S_UPDATE;
            end
            nsr_pkg::S_UPDATE: n_state = nsr_pkg::S_CONV;
            nsr_pkg::S_CONV: begin
                n_state = converged ? nsr_pkg::S_DONE : nsr_pkg::S_CHECK;
            end
            nsr_pkg::S_DONE:   n_state = nsr_pkg::S_IDLE;
            default:           n_state = nsr_pkg::S_IDLE;
        endcase
    end

    // datapath next values
    always_comb begin
        n_status = r_status;
        n_x      = r_x;
        n_x_prev = r_x_prev;
        n_limit  = r_limit;
        n_steps  = r_steps;
        n_prod   = r_prod;
        n_neg    = r_neg;
        n_dvd    = r_dvd;
        n_dsr    = r_dsr;
        n_rem    = r_rem;
        n_cnt    = r_cnt;
        case (r_state)
            nsr_pkg::S_IDLE: begin
                if (start) begin
                    n_x      = i_initial_guess;
                    n_limit  = lim_in;
                    n_steps  = '0;
                    n_status = nsr_pkg::STAT_LIMIT;
                end
            end
            nsr_pkg::S_CHECK: begin
                if (r_steps >= r_limit) begin
                    n_status = nsr_pkg::STAT_LIMIT;
                end else if (r_x == '0) begin
                    n_status = nsr_pkg::STAT_ZERO;
                end
            end
            nsr_pkg::S_MUL: begin
                n_prod = sq;
            end
            nsr_pkg::S_PREP: begin
                n_neg = num[PW-1] ^ r_x[XW-1];
                n_dvd = num_abs[DW-1:0];
                n_dsr = {x_mag, 1'b0};
                n_rem = '0;
                n_cnt = '0;
            end
            nsr_pkg::S_DIV: begin
                n_rem = q_bit ? rem_sub[SW-1:0] : rem_sh[SW-1:0];
                n_dvd = {r_dvd[DW-2:0], q_bit};
                n_cnt = r_cnt + 1'b1;
            end
            nsr_pkg::S_UPDATE: begin
                n_x_prev = r_x;
                n_x      = nx_sat;
                n_steps  = r_steps + 1'b1;
            end
            nsr_pkg::S_CONV: begin
                if (converged) n_status = nsr_pkg::STAT_CONVERGED;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= nsr_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_x      <= n_x;
        r_x_prev <= n_x_prev;
        r_limit  <= n_limit;
        r_steps  <= n_steps;
        r_prod   <= n_prod;
        r_neg    <= n_neg;
        r_dvd    <= n_dvd;
        r_dsr    <= n_dsr;
        r_rem    <= n_rem;
        r_cnt    <= n_cnt;
    end

    // outputs
    always_comb begin
        busy          = (r_state != nsr_pkg::S_IDLE);
        o_valid       = (r_state == nsr_pkg::S_DONE);
        o_root        = r_x;
        o_status      = r_status;
        o_steps_taken = steps_ext[nsr_pkg::STEPS_W-1:0];
    end

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held longer than one cycle");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy && !o_valid)
        else $error("accepted word did not make the block busy");

    a_zero_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == nsr_pkg::STAT_ZERO |-> o_root == '0)
        else $error("zero derivative status with nonzero root");

    a_div_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == nsr_pkg::S_UPDATE |-> $past(div_last))
        else $error("divider ended before all quotient bits were formed");

endmodule
